[design/sed_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the string escape decoder.
// Used by the front end, the command queue, the back end and the top level.
package sed_pkg;

  // Default number of command entries between front and back end.
  localparam int unsigned QueueDepthDefault = 4;

  // Most result beats that one source byte can cause.
  localparam int unsigned MaxBeats = 4;

  // Status code carried with every result beat.
  typedef enum logic [2:0] {
    ST_BYTE       = 3'd0,
    ST_CLOSED     = 3'd1,
    ST_UNTERM     = 3'd2,
    ST_INCOMPLETE = 3'd3,
    ST_BAD_HEX    = 3'd4,
    ST_BAD_CP     = 3'd5,
    ST_OCT_RANGE  = 3'd6,
    ST_BAD_ESC    = 3'd7
  } status_e;

  // One result beat.
  typedef struct packed {
    logic [7:0] data;
    status_e    status;
  } res_t;

  // Everything one source byte produces: a beat count of 0 to 4 and the beats.
  typedef struct packed {
    logic [2:0]            count;
    res_t [MaxBeats-1:0]   res;
  } cmd_t;

  // Queue occupancy flags, seen by the back end and the top level.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_flags_t;

endpackage

[design/sed_front.sv]
`timescale 1ns / 1ps
// Front end of the string escape decoder: escape state machine and result forming.
// Depends on sed_pkg for the status codes and the command type.
module sed_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    in_byte_i,
  input  logic          end_of_input_i,
  output logic          push_o,
  output sed_pkg::cmd_t cmd_o
);
  import sed_pkg::*;

  // Phase codes of the decoder.
  localparam logic [2:0] PH_BODY = 3'd0;
  localparam logic [2:0] PH_ESC  = 3'd1;
  localparam logic [2:0] PH_HEX  = 3'd2;
  localparam logic [2:0] PH_OCT  = 3'd3;

  // Source characters with a meaning of their own.
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_NL    = 8'h0A;

  logic [2:0]  phase_q, phase_d;
  logic [3:0]  digits_q, digits_d;
  logic [31:0] acc_q, acc_d;
  logic        uni_q, uni_d;

  logic        hex_ok;
  logic [3:0]  hex_val;
  logic        oct_ok;
  logic [3:0]  dig_dec;
  logic        body_has;
  res_t        body_res;
  logic [2:0]  body_phase;
  res_t        oct_res;
  cmd_t        cmd;

  // Build a single result beat.
  function automatic res_t mk_res(logic [7:0] data, status_e st);
    res_t r;
    r.data   = data;
    r.status = st;
    return r;
  endfunction

  // Encode a code point as 1 to 4 UTF-8 beats, or as a bad code point error.
  function automatic cmd_t utf8_cmd(logic [31:0] cp);
    cmd_t c;
    c = '0;
    if (cp <= 32'h7F) begin
      c.count  = 3'd1;
      c.res[0] = mk_res(cp[7:0], ST_BYTE);
    end else if (cp <= 32'h7FF) begin
      c.count  = 3'd2;
      c.res[0] = mk_res(8'hC0 | {3'b000, cp[10:6]}, ST_BYTE);
      c.res[1] = mk_res(8'h80 | {2'b00, cp[5:0]}, ST_BYTE);
    end else if (cp <= 32'hFFFF) begin
      c.count  = 3'd3;
      c.res[0] = mk_res(8'hE0 | {4'h0, cp[15:12]}, ST_BYTE);
      c.res[1] = mk_res(8'h80 | {2'b00, cp[11:6]}, ST_BYTE);
      c.res[2] = mk_res(8'h80 | {2'b00, cp[5:0]}, ST_BYTE);
    end else if (cp <= 32'h1FFFFF) begin
      c.count  = 3'd4;
      c.res[0] = mk_res(8'hF0 | {5'h00, cp[20:18]}, ST_BYTE);
      c.res[1] = mk_res(8'h80 | {2'b00, cp[17:12]}, ST_BYTE);
      c.res[2] = mk_res(8'h80 | {2'b00, cp[11:6]}, ST_BYTE);
      c.res[3] = mk_res(8'h80 | {2'b00, cp[5:0]}, ST_BYTE);
    end else begin
      c.count  = 3'd1;
      c.res[0] = mk_res(8'h00, ST_BAD_CP);
    end
    return c;
  endfunction

  // Classify the source byte as a hex or octal digit.
  always_comb begin
    hex_ok  = 1'b0;
    hex_val = 4'h0;
    if (in_byte_i >= 8'h30 && in_byte_i <= 8'h39) begin
      hex_ok  = 1'b1;
      hex_val = in_byte_i[3:0];
    end else if ((in_byte_i >= 8'h61 && in_byte_i <= 8'h66) ||
                 (in_byte_i >= 8'h41 && in_byte_i <= 8'h46)) begin
      hex_ok  = 1'b1;
      hex_val = in_byte_i[3:0] + 4'd9;
    end
    hex_ok = hex_ok && !end_of_input_i;
    oct_ok = !end_of_input_i && (in_byte_i >= 8'h30) && (in_byte_i <= 8'h37);
    dig_dec = (digits_q != 4'd0) ? digits_q - 4'd1 : 4'd0;
  end

  // What the byte means when it lands in the literal body.
  always_comb begin
    body_has   = 1'b1;
    body_phase = PH_BODY;
    body_res   = mk_res(in_byte_i, ST_BYTE);
    if (end_of_input_i) begin
      body_res = mk_res(8'h00, ST_UNTERM);
    end else if (in_byte_i == CH_QUOTE) begin
      body_res = mk_res(8'h00, ST_CLOSED);
    end else if (in_byte_i == CH_BSL) begin
      body_has   = 1'b0;
      body_phase = PH_ESC;
    end
  end

  // Value of a finished octal escape, collected so far in the accumulator.
  assign oct_res = (acc_q[31:8] != 24'd0) ? mk_res(8'h00, ST_OCT_RANGE)
                                          : mk_res(acc_q[7:0], ST_BYTE);

  // Escape state machine and the command that each source byte causes.
  always_comb begin
    phase_d  = phase_q;
    digits_d = digits_q;
    acc_d    = acc_q;
    uni_d    = uni_q;
    cmd      = '0;
    unique case (phase_q)
      PH_ESC: begin
        phase_d   = PH_BODY;
        cmd.count = 3'd1;
        if (end_of_input_i) begin
          cmd.res[0] = mk_res(8'h00, ST_INCOMPLETE);
        end else begin
          unique case (in_byte_i)
            CH_BSL:   cmd.res[0] = mk_res(CH_BSL, ST_BYTE);
            CH_QUOTE: cmd.res[0] = mk_res(CH_QUOTE, ST_BYTE);
            8'h74:    cmd.res[0] = mk_res(8'h09, ST_BYTE);
            8'h6E:    cmd.res[0] = mk_res(8'h0A, ST_BYTE);
            8'h72:    cmd.res[0] = mk_res(8'h0D, ST_BYTE);
            8'h62:    cmd.res[0] = mk_res(8'h08, ST_BYTE);
            8'h61:    cmd.res[0] = mk_res(8'h07, ST_BYTE);
            8'h65:    cmd.res[0] = mk_res(8'h1B, ST_BYTE);
            8'h66:    cmd.res[0] = mk_res(8'h0C, ST_BYTE);
            8'h76:    cmd.res[0] = mk_res(8'h0B, ST_BYTE);
            CH_NL:    cmd.count  = 3'd0;
            8'h78, 8'h75, 8'h55: begin
              // Hex escape: \x takes two digits, \u four and \U eight.
              cmd.count = 3'd0;
              phase_d   = PH_HEX;
              acc_d     = 32'd0;
              uni_d     = (in_byte_i != 8'h78);
              if (in_byte_i == 8'h78) begin
                digits_d = 4'd2;
              end else if (in_byte_i == 8'h75) begin
                digits_d = 4'd4;
              end else begin
                digits_d = 4'd8;
              end
            end
            default: begin
              if (oct_ok) begin
                cmd.count = 3'd0;
                phase_d   = PH_OCT;
                acc_d     = {29'd0, in_byte_i[2:0]};
                digits_d  = 4'd2;
              end else begin
                cmd.res[0] = mk_res(8'h00, ST_BAD_ESC);
              end
            end
          endcase
        end
      end
      PH_HEX: begin
        if (!hex_ok) begin
          phase_d    = PH_BODY;
          cmd.count  = 3'd1;
          cmd.res[0] = mk_res(8'h00, ST_BAD_HEX);
        end else begin
          acc_d    = {acc_q[27:0], hex_val};
          digits_d = dig_dec;
          if (dig_dec == 4'd0) begin
            phase_d = PH_BODY;
            if (uni_q) begin
              cmd = utf8_cmd({acc_q[27:0], hex_val});
            end else begin
              cmd.count  = 3'd1;
              cmd.res[0] = mk_res({acc_q[3:0], hex_val}, ST_BYTE);
            end
          end
        end
      end
      PH_OCT: begin
        if (oct_ok) begin
          // Octal values are kept to twelve bits.
          acc_d    = {20'd0, acc_q[8:0], in_byte_i[2:0]};
          digits_d = dig_dec;
          if (dig_dec == 4'd0) begin
            phase_d   = PH_BODY;
            cmd.count = 3'd1;
            if (acc_q[8:5] != 4'd0) begin
              cmd.res[0] = mk_res(8'h00, ST_OCT_RANGE);
            end else begin
              cmd.res[0] = mk_res({acc_q[4:0], in_byte_i[2:0]}, ST_BYTE);
            end
          end
        end else begin
          // The escape ends early: give its byte, then treat this input as body.
          phase_d    = body_phase;
          cmd.count  = body_has ? 3'd2 : 3'd1;
          cmd.res[0] = oct_res;
          cmd.res[1] = body_res;
        end
      end
      default: begin
        phase_d    = body_phase;
        cmd.count  = body_has ? 3'd1 : 3'd0;
        cmd.res[0] = body_res;
      end
    endcase
  end

  assign push_o = accept_i && (cmd.count != 3'd0);
  assign cmd_o  = cmd;

  // Decoder state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_BODY;
      digits_q <= 4'd0;
      acc_q    <= 32'd0;
      uni_q    <= 1'b0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      digits_q <= digits_d;
      acc_q    <= acc_d;
      uni_q    <= uni_d;
    end
  end

endmodule

[design/sed_queue.sv]
`timescale 1ns / 1ps
// Command queue between the front and back end of the string escape decoder.
// Depends on sed_pkg for the command and flag types.
module sed_queue #(
  parameter int unsigned Depth = sed_pkg::QueueDepthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  sed_pkg::cmd_t         cmd_i,
  input  logic                  pop_i,
  output sed_pkg::cmd_t         head_o,
  output sed_pkg::queue_flags_t flags_o
);
  import sed_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  // Entry storage, written at the tail.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  assign head_o        = entry_q[rd_ptr_q];
  assign flags_o.full  = (count_q == CntW'(Depth));
  assign flags_o.empty = (count_q == '0);

endmodule

[design/sed_back.sv]
`timescale 1ns / 1ps
// Back end of the string escape decoder: plays each command out as result beats.
// Depends on sed_pkg for the command and flag types.
module sed_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sed_pkg::cmd_t         head_i,
  input  sed_pkg::queue_flags_t flags_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            out_byte_o,
  output logic [2:0]            status_o,
  output logic                  last_o
);
  import sed_pkg::*;

  logic       valid_q;
  logic [1:0] idx_q;
  logic [7:0] byte_q;
  status_e    status_q;
  logic       last_q;
  logic       load;
  logic       take;
  logic       final_beat;
  res_t       cur;

  // The output register refills when it is empty or its beat leaves.
  assign load       = !valid_q || !out_stall_i;
  assign take       = load && !flags_i.empty;
  assign cur        = head_i.res[idx_q];
  assign final_beat = ({1'b0, idx_q} == head_i.count - 3'd1);
  assign pop_o      = take && final_beat;

  // Beat index within the head command.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= !flags_i.empty;
      if (take) begin
        idx_q <= final_beat ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q   <= cur.data;
      status_q <= cur.status;
      last_q   <= final_beat;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

endmodule

[design/string_escape_decoder_core.sv]
`timescale 1ns / 1ps
// Top level of the string escape decoder: front end, command queue and back end.
// Depends on sed_pkg, sed_front, sed_queue and sed_back.
//
//   Channel  Direction  Handshake               Payload
//   in       sink       in_valid_i/in_stall_o   in_byte_i, end_of_input_i
//   out      source     out_valid_o/out_stall_i out_byte_o, status_o, last_o
//
// A source byte is decoded in the cycle it is taken and queued at that edge; the back end then loads
// its first beat into the output register, then one beat per cycle while out_stall_i is low.
// The back end's single output port sets the rate: UTF-8 sequences give up to four beats.
// in_stall_o is high only while the command queue is full.
// Reset returns the decoder to the literal body and empties the queue.
module string_escape_decoder_core #(
  parameter int unsigned QueueDepth = sed_pkg::QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_input_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [2:0] status_o,
  output logic       last_o
);
  import sed_pkg::*;

  logic         accept;
  logic         push;
  logic         pop;
  cmd_t         cmd;
  cmd_t         head;
  queue_flags_t flags;

  assign in_stall_o = flags.full;
  assign accept     = in_valid_i && !flags.full;

  // Escape decoding of each source beat.
  sed_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .in_byte_i      (in_byte_i),
    .end_of_input_i (end_of_input_i),
    .push_o         (push),
    .cmd_o          (cmd)
  );

  // Commands waiting for the output side.
  sed_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .head_o  (head),
    .flags_o (flags)
  );

  // Result beats out of the head command.
  sed_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .flags_i     (flags),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

  // The queue is never written while full.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !flags.full)
    else $error("command written into a full queue");

  // Status beats carry a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_BYTE)) |-> (out_byte_o == 8'h00))
    else $error("status beat with a non-zero byte");

  // A command's remaining beats follow without a gap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) |=> out_valid_o)
    else $error("gap inside a multi-beat result");

  // A popped command leaves the queue non-full on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> !flags.full)
    else $error("queue still full after a pop");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for string_escape_decoder_core: directed and random literal bodies.
// Depends on sed_pkg and the string_escape_decoder_core RTL only.
module testbench;
  import sed_pkg::*;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned TailCycles    = 24;
  localparam int unsigned BytesPerPhase = 46;
  localparam int unsigned DirectedRows  = 28;
  localparam int unsigned ReportLimit   = 10;

  // Decoder phase as the predictor tracks it.
  typedef enum logic [1:0] {
    DEC_BODY,
    DEC_ESC,
    DEC_HEX,
    DEC_OCT
  } dec_phase_e;

  // Kinds of fragment that the random part strings together.
  typedef enum int {
    TK_PLAIN,
    TK_SIMPLE,
    TK_HEX,
    TK_UNI4,
    TK_UNI8,
    TK_OCT,
    TK_CLOSE,
    TK_END,
    TK_BROKEN
  } token_e;

  typedef struct packed {
    logic [7:0] data;
    status_e    status;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eoi;
  } src_t;

  // A directed row; typed rows carry the single beat they must give.
  typedef struct packed {
    logic [7:0] b;
    logic       eoi;
    logic       typed;
    logic [7:0] data;
    status_e    status;
  } row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] in_byte_i;
  logic       end_of_input_i;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic [2:0] status_o;
  logic       last_o;

  // Predictor state.
  dec_phase_e  ph = DEC_BODY;
  logic [3:0]  digits_left = '0;
  logic [31:0] acc = '0;
  logic        uni_esc = 1'b0;

  beat_t pending_beats[$];
  beat_t expected_beats[$];
  src_t  source_bytes[$];
  row_t  directed_rows[DirectedRows];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fail_count     = 0;
  int unsigned items_sent     = 0;
  int unsigned beats_checked  = 0;
  int unsigned quiet_cycles   = 0;

  string_escape_decoder_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .end_of_input_i(end_of_input_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int hex_val(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic void emit(logic [7:0] data, status_e st);
    beat_t nb;
    nb = '{data, st, 1'b0};
    if (pending_beats.size() < MaxBeats) pending_beats.insert(pending_beats.size(), nb);
  endfunction

  // A code point becomes one to four UTF-8 bytes, bounds inclusive.
  function automatic void encode_cp(logic [31:0] cp);
    if (cp <= 32'h7F) begin
      emit(cp[7:0], ST_BYTE);
    end else if (cp <= 32'h7FF) begin
      emit({3'b110, cp[10:6]}, ST_BYTE);
      emit({2'b10, cp[5:0]}, ST_BYTE);
    end else if (cp <= 32'hFFFF) begin
      emit({4'b1110, cp[15:12]}, ST_BYTE);
      emit({2'b10, cp[11:6]}, ST_BYTE);
      emit({2'b10, cp[5:0]}, ST_BYTE);
    end else if (cp <= 32'h1FFFFF) begin
      emit({5'b11110, cp[20:18]}, ST_BYTE);
      emit({2'b10, cp[17:12]}, ST_BYTE);
      emit({2'b10, cp[11:6]}, ST_BYTE);
      emit({2'b10, cp[5:0]}, ST_BYTE);
    end else begin
      emit(8'h00, ST_BAD_CP);
    end
  endfunction

  function automatic void body_byte(logic [7:0] b, logic e);
    ph = DEC_BODY;
    if (e) emit(8'h00, ST_UNTERM);
    else if (b == CH_QUOTE) emit(8'h00, ST_CLOSED);
    else if (b == CH_BSLASH) ph = DEC_ESC;
    else emit(b, ST_BYTE);
  endfunction

  function automatic void start_hex(logic [3:0] count, logic uni);
    ph = DEC_HEX;
    digits_left = count;
    acc = '0;
    uni_esc = uni;
  endfunction

  function automatic void octal_result();
    if (acc > 32'd255) emit(8'h00, ST_OCT_RANGE);
    else emit(acc[7:0], ST_BYTE);
  endfunction

  // The byte after a backslash picks the escape.
  function automatic void escape_byte(logic [7:0] b, logic e);
    ph = DEC_BODY;
    if (e) begin
      emit(8'h00, ST_INCOMPLETE);
    end else begin
      case (b)
        CH_BSLASH: emit(CH_BSLASH, ST_BYTE);
        CH_QUOTE:  emit(CH_QUOTE, ST_BYTE);
        "t":       emit(8'd9, ST_BYTE);
        "n":       emit(8'd10, ST_BYTE);
        "r":       emit(8'd13, ST_BYTE);
        "b":       emit(8'd8, ST_BYTE);
        "a":       emit(8'd7, ST_BYTE);
        "e":       emit(8'h1B, ST_BYTE);
        "f":       emit(8'd12, ST_BYTE);
        "v":       emit(8'd11, ST_BYTE);
        CH_NL:     ;
        "x":       start_hex(4'd2, 1'b0);
        "u":       start_hex(4'd4, 1'b1);
        "U":       start_hex(4'd8, 1'b1);
        default: begin
          if (b >= "0" && b <= "7") begin
            ph = DEC_OCT;
            acc = {29'd0, b[2:0]};
            digits_left = 4'd2;
          end else begin
            emit(8'h00, ST_BAD_ESC);
          end
        end
      endcase
    end
  endfunction

  // Works out the beats that one source byte causes, leaving them in pending_beats.
  function automatic void decode_byte(logic [7:0] b, logic e);
    int d;
    pending_beats.delete();
    case (ph)
      DEC_ESC: escape_byte(b, e);
      DEC_HEX: begin
        d = e ? -1 : hex_val(b);
        if (d < 0) begin
          ph = DEC_BODY;
          emit(8'h00, ST_BAD_HEX);
        end else begin
          acc = {acc[27:0], 4'(d)};
          if (digits_left > 0) digits_left = digits_left - 4'd1;
          if (digits_left == 0) begin
            ph = DEC_BODY;
            if (uni_esc) encode_cp(acc);
            else emit(acc[7:0], ST_BYTE);
          end
        end
      end
      DEC_OCT: begin
        if (!e && b >= "0" && b <= "7") begin
          acc = {acc[28:0], b[2:0]} & 32'hFFF;
          if (digits_left > 0) digits_left = digits_left - 4'd1;
          if (digits_left == 0) begin
            ph = DEC_BODY;
            octal_result();
          end
        end else begin
          // A non-octal byte ends the escape and is then taken as body text.
          octal_result();
          body_byte(b, e);
        end
      end
      default: body_byte(b, e);
    endcase
    if (pending_beats.size() > 0) pending_beats[pending_beats.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Random literal fragments
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return "0" + 8'(n);
    return ($urandom_range(1) ? "a" : "A") + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (hex_val(b) >= 0) b = 8'($urandom_range(255));
    return b;
  endfunction

  function automatic void push_src(logic [7:0] b, logic e);
    src_t sb;
    sb = '{b, e};
    source_bytes.insert(source_bytes.size(), sb);
  endfunction

  function automatic void push_hex_digits(logic [31:0] value, int count);
    for (int i = count - 1; i >= 0; i--) push_src(hex_char(value[4*i +: 4]), 1'b0);
  endfunction

  function automatic logic [31:0] pick_codepoint();
    logic [31:0] edges[10];
    edges = '{32'h0, 32'h7F, 32'h80, 32'h7FF, 32'h800, 32'hFFFF, 32'h10000,
              32'h1FFFFF, 32'h200000, 32'hFFFFFFFF};
    case ($urandom_range(4))
      0: return 32'($urandom_range(32'hFFFF));
      1: return 32'($urandom_range(32'h1FFFFF, 32'h10000));
      2: return edges[$urandom_range(9)];
      3: return $urandom;
      default: return 32'($urandom_range(32'h1FFFFF));
    endcase
  endfunction

  // Appends one well-formed or deliberately broken fragment of literal text.
  function automatic void add_fragment();
    logic [7:0] simple_esc[11];
    logic [7:0] intro[3];
    int         need[3];
    int         pick;
    int         sel;
    token_e     kind;
    logic [15:0] cp16;
    simple_esc = '{CH_BSLASH, CH_QUOTE, "t", "n", "r", "b", "a", "e", "f", "v", CH_NL};
    intro = '{"x", "u", "U"};
    need = '{2, 4, 8};
    pick = $urandom_range(99);
    if (pick < 30) kind = TK_PLAIN;
    else if (pick < 42) kind = TK_SIMPLE;
    else if (pick < 50) kind = TK_HEX;
    else if (pick < 60) kind = TK_UNI4;
    else if (pick < 68) kind = TK_UNI8;
    else if (pick < 78) kind = TK_OCT;
    else if (pick < 84) kind = TK_CLOSE;
    else if (pick < 88) kind = TK_END;
    else kind = TK_BROKEN;

    case (kind)
      TK_PLAIN: push_src(8'($urandom_range(255)), 1'b0);
      TK_SIMPLE: begin
        push_src(CH_BSLASH, 1'b0);
        push_src(simple_esc[$urandom_range(10)], 1'b0);
      end
      TK_HEX: begin
        push_src(CH_BSLASH, 1'b0);
        push_src("x", 1'b0);
        push_hex_digits(32'($urandom_range(255)), 2);
      end
      TK_UNI4: begin
        case ($urandom_range(2))
          0: cp16 = 16'($urandom_range(16'h7F));
          1: cp16 = 16'($urandom_range(16'h7FF, 16'h80));
          default: cp16 = 16'($urandom);
        endcase
        push_src(CH_BSLASH, 1'b0);
        push_src("u", 1'b0);
        push_hex_digits({16'd0, cp16}, 4);
      end
      TK_UNI8: begin
        push_src(CH_BSLASH, 1'b0);
        push_src("U", 1'b0);
        push_hex_digits(pick_codepoint(), 8);
      end
      TK_OCT: begin
        push_src(CH_BSLASH, 1'b0);
        sel = $urandom_range(1, 3);
        for (int i = 0; i < sel; i++) push_src("0" + 8'($urandom_range(7)), 1'b0);
      end
      TK_CLOSE: push_src(CH_QUOTE, 1'b0);
      TK_END: push_src(8'($urandom_range(255)), 1'b1);
      default: begin
        push_src(CH_BSLASH, 1'b0);
        case ($urandom_range(3))
          0: push_src(8'($urandom_range(255)), 1'b0);
          1, 2: begin
            // Hex escape cut short by a stray byte or by the end of the source.
            sel = $urandom_range(2);
            push_src(intro[sel], 1'b0);
            push_hex_digits($urandom, $urandom_range(need[sel] - 1));
            if ($urandom_range(1)) push_src(non_hex_byte(), 1'b0);
            else push_src(8'($urandom_range(255)), 1'b1);
          end
          default: push_src(8'($urandom_range(255)), 1'b1);
        endcase
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Source side
  // ---------------------------------------------------------------------------

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_byte(input logic [7:0] b, input logic e, input logic typed,
                           input beat_t typed_beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_byte_i      <= b;
    end_of_input_i <= e;
    do @(posedge clk_i); while (in_stall_o);
    decode_byte(b, e);
    if (typed) expected_beats.insert(expected_beats.size(), typed_beat);
    else foreach (pending_beats[k]) expected_beats.insert(expected_beats.size(),
                                                          pending_beats[k]);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Holds the source back until every expected beat has come out.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic report_mismatch(input string what, input beat_t want, input beat_t got);
    fail_count++;
    if (fail_count <= ReportLimit) begin
      $display("%0t: %s: expected data %02h status %0d last %0b,",
               $realtime, what, want.data, want.status, want.last);
      $display("    got data %02h status %0d last %0b", got.data, got.status, got.last);
    end
  endtask

  // Every beat taken is compared with the oldest expectation.
  always @(posedge clk_i) begin
    beat_t got;
    beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{out_byte_o, status_e'(status_o), last_o};
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat", '0, got);
      end else begin
        want = expected_beats.pop_front();
        if (got !== want) report_mismatch("beat mismatch", want, got);
      end
      beats_checked++;
    end
  end

  // Ends the run when neither channel moves a beat for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Watchdog: no beat moved for %0d cycles, %0d beats still expected",
               quiet_cycles, expected_beats.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned send_pcts[4];
    int unsigned recv_pcts[4];
    src_t        s;
    send_pcts = '{0, 55, 0, 34};
    recv_pcts = '{0, 0, 55, 34};

    // Extremes, closing quote, end of source and every error kind.
    directed_rows = '{
      '{8'h00,     1'b0, 1'b1, 8'h00, ST_BYTE},
      '{8'hFF,     1'b0, 1'b1, 8'hFF, ST_BYTE},
      '{CH_QUOTE,  1'b0, 1'b1, 8'h00, ST_CLOSED},
      '{8'hFF,     1'b1, 1'b1, 8'h00, ST_UNTERM},
      '{CH_BSLASH, 1'b0, 1'b0, 8'h00, ST_BYTE},
      '{"q",       1'b0, 1'b1, 8'h00, ST_BAD_ESC},
      '{CH_BSLASH, 1'b0, 1'b0, 8'h00, ST_BYTE},
      '{"x",       1'b0, 1'b0, 8'h00, ST_BYTE},
      '{"g",       1'b0, 1'b1, 8'h00, ST_BAD_HEX},
      '{CH_BSLASH, 1'b0, 1'b0, 8'h00, ST_BYTE},
      '{"U",       1'b0, 1'b0, 8'h00, ST_BYTE},
      '{"0",       1'b0, 1'b0, 8'h00, ST_BYTE},
      '{"0",       1'b0, 1'b0, 8'h00, ST_BYTE},
      '{"2",       1'b0, 1'b0, 8'h00, ST_BYTE},
      '{"0",       1'b0, 1'b0, 8'h00, ST_BYTE},
      '{"0",       1'b0, 1'b0, 8'h00, ST_BYTE},
      '{"0",       1'b0, 1'b0, 8'h00, ST_BYTE},
      '{"0",       1'b0, 1'b0, 8'h00, ST_BYTE},
      '{"0",       1'b0, 1'b1, 8'h00, ST_BAD_CP},
      '{CH_BSLASH, 1'b0, 1'b0, 8'h00, ST_BYTE},
      '{"4",       1'b0, 1'b0, 8'h00, ST_BYTE},
      '{"0",       1'b0, 1'b0, 8'h00, ST_BYTE},
      '{"0",       1'b0, 1'b1, 8'h00, ST_OCT_RANGE},
      '{CH_BSLASH, 1'b0, 1'b0, 8'h00, ST_BYTE},
      '{"7",       1'b0, 1'b0, 8'h00, ST_BYTE},
      // Octal escape cut off by the end of the source: byte, then unterminated.
      '{8'h00,     1'b1, 1'b0, 8'h00, ST_BYTE},
      '{CH_BSLASH, 1'b0, 1'b0, 8'h00, ST_BYTE},
      '{8'h5A,     1'b1, 1'b1, 8'h00, ST_INCOMPLETE}
    };

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_byte_i      = 8'h00;
    end_of_input_i = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed rows, walked with no idling on either side.
    foreach (directed_rows[r]) begin
      send_byte(directed_rows[r].b, directed_rows[r].eoi, directed_rows[r].typed,
                '{directed_rows[r].data, directed_rows[r].status, 1'b1});
    end

    // Random literal text under each idling regime, draining before each one.
    for (int p = 0; p < 4; p++) begin
      drain_results();
      send_idle_pct  = send_pcts[p];
      recv_stall_pct = recv_pcts[p];
      while (source_bytes.size() < BytesPerPhase) add_fragment();
      while (source_bytes.size() != 0) begin
        s = source_bytes.pop_front();
        send_byte(s.b, s.eoi, 1'b0, '0);
      end
    end

    drain_results();
    repeat (TailCycles) @(negedge clk_i);
    if (expected_beats.size() != 0) fail_count++;

    $display("Sent %0d source bytes (%0d directed) and checked %0d decoded beats,",
             items_sent, DirectedRows, beats_checked);
    $display("with the source and sink idle, stalling, both, and neither.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d failures", fail_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
